/* rtl/sph_pkg.sv */
`default_nettype none

package sph_pkg;

  // grid geometry
  localparam int BINS  = 512;
  localparam int ROWS  = 100;
  localparam int CELLS = BINS * ROWS;
  localparam int IDX_W = $clog2(CELLS);
  localparam int ROW_W = (ROWS > 2) ? $clog2(ROWS) : 1;

  // field widths
  localparam int COL_W     = 9;
  localparam int LEVEL_W   = 10;
  localparam int COUNT_W   = 8;
  localparam int HOLD_W    = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LATE_HOLD    = 1'd1;

  // count thresholds and reset values
  localparam logic [COUNT_W-1:0] CNT_LATE_MAX = 8'd20;
  localparam logic [COUNT_W-1:0] CNT_FAST_LIM = 8'd220;
  localparam logic [COUNT_W-1:0] CNT_SAT      = 8'd239;
  localparam logic [COUNT_W-1:0] CNT_FAST_INC = 8'd4;
  localparam logic [HOLD_W-1:0]  HOLD_RST     = 8'h07;
  localparam logic [CFG_W-1:0]   DECAY_PERIOD_RST = 8'd4;
  localparam logic [CFG_W-1:0]   LATE_HOLD_RST    = 8'd20;

  typedef enum logic {
    ACT_ACCUMULATE = 1'b0,
    ACT_READ       = 1'b1
  } action_t;

  typedef enum logic {
    ALU_ACCUMULATE = 1'b0,
    ALU_DECAY      = 1'b1
  } alu_mode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SWEEP,
    S_SWEEP_END,
    S_ACC_RD,
    S_ACC_WB,
    S_RD_ISSUE,
    S_RD_DATA
  } state_t;

  typedef struct packed {
    logic [HOLD_W-1:0]  hold;
    logic [COUNT_W-1:0] count;
  } cell_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    cell_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

/* rtl/spectrum_persistence_histogram.sv */
`default_nettype none

// channel  | dir | handshake        | payload
// ---------+-----+------------------+------------------------------------------
// in_      | in  | tvalid / tready  | tuser action, tdata column/level/first
// out_     | out | tvalid / tready  | tdata cell_count
// cfg_     | in  | we               | index, wdata (decay_period, late_hold)
//
// after reset a clearing pass writes every cell, no beat taken
// accumulate: index, read, write-back; off the grid only the index step
// read: index, memory read, then output wait; off the grid the memory read is skipped
// decay sweep: one cell per cycle through the shared cell unit over the whole grid,
// run before the accumulate on every decay_period-th first-of-spectrum beat
// one memory read port and one write port set the sweep rate
// a finished read waits in the output register; a later read waits behind it
module spectrum_persistence_histogram (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input beats
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic                            in_tuser,  // [0] action
  // [8:0] column, [18:9] level, [19] first_of_spectrum, [23:20] zero
  input  wire logic [sph_pkg::IN_DATA_W-1:0]   in_tdata,
  // result beats
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [sph_pkg::OUT_DATA_W-1:0]       out_tdata, // [7:0] cell_count
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [sph_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sph_pkg::CFG_W-1:0]       cfg_wdata
);
  import sph_pkg::*;

  // unpacked input fields
  logic [COL_W-1:0]   in_column;
  logic [LEVEL_W-1:0] in_level;
  logic               in_first;
  action_t            in_action;

  assign in_column = in_tdata[COL_W-1:0];
  assign in_level  = in_tdata[COL_W+LEVEL_W-1:COL_W];
  assign in_first  = in_tdata[COL_W+LEVEL_W];
  assign in_action = action_t'(in_tuser);

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               ok_r, ok_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic               pipe_v_r, pipe_v_nxt;
  logic [IDX_W-1:0]   pipe_addr_r, pipe_addr_nxt;
  logic [CFG_W-1:0]   countdown_r, countdown_nxt;
  logic [CFG_W-1:0]   decay_period_r, decay_period_nxt;
  logic [CFG_W-1:0]   late_hold_r, late_hold_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [COUNT_W-1:0] out_tdata_r, out_tdata_nxt;

  logic      accept;
  logic      in_ok;
  logic      ptr_last;
  logic      expire;
  logic      out_free;
  mem_req_t  mem_req;
  cell_t     mem_rdata;
  cell_t     alu_out;
  alu_mode_t alu_mode;

  assign accept   = in_tvalid & in_tready;
  assign ptr_last = (ptr_r == IDX_W'(CELLS - 1));
  assign expire   = (countdown_r <= CFG_W'(1));
  assign out_free = ~out_tvalid_r | out_tready;

  // cell in grid: row non-negative and below ROWS, column below BINS
  assign in_ok = ~in_level[LEVEL_W-1]
               & (in_level < LEVEL_W'(ROWS))
               & (32'(in_column) < 32'(BINS));

  // grid storage and shared cell unit
  sph_cell_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  sph_cell_alu u_alu (
    .mode      (alu_mode),
    .late_hold (late_hold_r),
    .cell_in   (mem_rdata),
    .cell_out  (alu_out)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (ptr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_READ) begin
            state_nxt = in_ok ? S_RD_ISSUE : S_RD_DATA;
          end else if (in_first && expire) begin
            state_nxt = S_SWEEP;
          end else if (in_ok) begin
            state_nxt = S_ACC_RD;
          end
        end
      end
      S_SWEEP: begin
        if (ptr_last) state_nxt = S_SWEEP_END;
      end
      S_SWEEP_END: begin
        state_nxt = ok_r ? S_ACC_RD : S_IDLE;
      end
      S_ACC_RD:   state_nxt = S_ACC_WB;
      S_ACC_WB:   state_nxt = S_IDLE;
      S_RD_ISSUE: state_nxt = S_RD_DATA;
      S_RD_DATA: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // state outputs: handshake, memory port, unit mode
  always_comb begin
    in_tready = 1'b0;
    alu_mode  = ALU_ACCUMULATE;
    mem_req   = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = ptr_r;
        mem_req.wdata.hold = HOLD_RST;
      end
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_SWEEP, S_SWEEP_END: begin
        // read cell ptr while writing back the previous one
        alu_mode      = ALU_DECAY;
        mem_req.re    = (state_r == S_SWEEP);
        mem_req.raddr = ptr_r;
        mem_req.we    = pipe_v_r;
        mem_req.waddr = pipe_addr_r;
        mem_req.wdata = alu_out;
      end
      S_ACC_RD, S_RD_ISSUE: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = idx_r;
      end
      S_ACC_WB: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = alu_out;
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    idx_nxt          = idx_r;
    ok_nxt           = ok_r;
    countdown_nxt    = countdown_r;
    decay_period_nxt = decay_period_r;
    late_hold_nxt    = late_hold_r;
    out_tvalid_nxt   = out_tvalid_r & ~out_tready;
    out_tdata_nxt    = out_tdata_r;
    pipe_v_nxt       = (state_r == S_SWEEP);
    pipe_addr_nxt    = ptr_r;
    ptr_nxt          = '0;

    if (state_r == S_CLEAR || state_r == S_SWEEP) begin
      ptr_nxt = ptr_r + 1'b1;
    end

    if (accept) begin
      // column * ROWS + row, registered before use
      idx_nxt = IDX_W'(in_column) * IDX_W'(ROWS) + IDX_W'(in_level[ROW_W-1:0]);
      ok_nxt  = in_ok;
      if (in_action == ACT_ACCUMULATE && in_first) begin
        countdown_nxt = expire ? decay_period_r : countdown_r - 1'b1;
      end
    end

    if (state_r == S_RD_DATA && out_free) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = ok_r ? mem_rdata.count : '0;
    end

    if (cfg_we) begin
      case (cfg_index)
        REG_DECAY_PERIOD: decay_period_nxt = cfg_wdata;
        REG_LATE_HOLD:    late_hold_nxt    = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      ptr_r          <= '0;
      pipe_v_r       <= 1'b0;
      countdown_r    <= DECAY_PERIOD_RST;
      decay_period_r <= DECAY_PERIOD_RST;
      late_hold_r    <= LATE_HOLD_RST;
      out_tvalid_r   <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      ptr_r          <= ptr_nxt;
      pipe_v_r       <= pipe_v_nxt;
      countdown_r    <= countdown_nxt;
      decay_period_r <= decay_period_nxt;
      late_hold_r    <= late_hold_nxt;
      out_tvalid_r   <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    ok_r        <= ok_nxt;
    pipe_addr_r <= pipe_addr_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

/* rtl/sph_cell_store.sv */
`default_nettype none

module sph_cell_store (
  input  wire logic             clk,
  input  wire sph_pkg::mem_req_t req,
  output sph_pkg::cell_t        rdata
);
  import sph_pkg::*;

  cell_t mem [CELLS];
  cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/sph_cell_alu.sv */
`default_nettype none

module sph_cell_alu (
  input  wire sph_pkg::alu_mode_t      mode,
  input  wire logic [sph_pkg::HOLD_W-1:0] late_hold,
  input  wire sph_pkg::cell_t          cell_in,
  output sph_pkg::cell_t               cell_out
);
  import sph_pkg::*;

  always_comb begin
    cell_out = cell_in;
    case (mode)
      ALU_DECAY: begin
        if (cell_in.count > CNT_LATE_MAX) begin
          cell_out.count = cell_in.count - 1'b1;
        end else if (cell_in.count != '0) begin
          if (cell_in.hold != '0) begin
            cell_out.hold = cell_in.hold - 1'b1;
          end else begin
            // late holdoff ran out: drop and reload
            cell_out.hold  = late_hold;
            cell_out.count = cell_in.count - 1'b1;
          end
        end
      end
      default: begin
        if (cell_in.count < CNT_FAST_LIM) begin
          cell_out.count = cell_in.count + CNT_FAST_INC;
        end else if (cell_in.count < CNT_SAT) begin
          cell_out.count = cell_in.count + 1'b1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

/* sim/spectrum_persistence_histogram_tb.sv */
`default_nettype none

module spectrum_persistence_histogram_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sph_pkg::*;

  // generous: twelve full-grid sweeps, the clearing pass and every beat stalled
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int          RX_HOLD_LEN = 600;
  localparam int          MAX_REPORTS = 10;
  localparam int          HOT_CELLS   = 8;

  // one input beat before packing
  typedef struct packed {
    action_t                   act;
    logic [COL_W-1:0]          col;
    logic signed [LEVEL_W-1:0] lvl;
    logic                      first;
  } beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  wire logic             in_tready;
  logic                  in_tuser = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  wire logic             out_tvalid;
  logic                  out_tready = 1'b0;
  wire logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  spectrum_persistence_histogram dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow of the grid, the cell holdoffs and the sweep countdown
  logic [COUNT_W-1:0] hit_cnt  [CELLS];
  logic [HOLD_W-1:0]  hold_cnt [CELLS];
  logic [CFG_W-1:0]   sweep_left;
  logic [CFG_W-1:0]   decay_period_reg;
  logic [CFG_W-1:0]   late_hold_reg;

  beat_t              pending_beats [$];
  logic [COUNT_W-1:0] cell_count_q  [$];
  beat_t              beat_on_bus;

  // stimulus-side copy of the countdown, used to ration the slow grid sweeps
  int                 gen_countdown;
  int                 gen_period;
  int                 sweeps_allowed;

  int                 errors = 0;
  int unsigned        cycle_cnt = 0;

  // sides of the handshake
  logic               calm = 1'b0;        // no idling at all while set
  logic               pressure_on = 1'b0;
  logic               pressure_done = 1'b0;
  int                 rx_hold_cnt = 0;
  wire logic          rx_holding = pressure_on && !pressure_done;

  // cells hit hard so that counts climb to saturation
  int hot_col [HOT_CELLS] = '{3, 77, 200, 511, 3, 300, 128, 450};
  int hot_row [HOT_CELLS] = '{0, 50, 99, 7, 98, 1, 64, 33};

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // whole-grid decay: fast drop above the late threshold, holdoff-gated below
  task automatic grid_decay();
    for (int i = 0; i < CELLS; i++) begin
      if (hit_cnt[i] > CNT_LATE_MAX) begin
        hit_cnt[i] = hit_cnt[i] - 1'b1;
      end else if (hit_cnt[i] != '0) begin
        if (hold_cnt[i] != '0) begin
          hold_cnt[i] = hold_cnt[i] - 1'b1;
        end else begin
          hold_cnt[i] = late_hold_reg;
          hit_cnt[i]  = hit_cnt[i] - 1'b1;
        end
      end
    end
  endtask

  // apply one accepted beat, queueing the cell count a read returns
  task automatic grid_apply(input beat_t b);
    bit on_grid;
    int idx;
    on_grid = (b.lvl >= 0) && (b.lvl < ROWS) && (int'(b.col) < BINS);
    idx = on_grid ? int'(b.col) * ROWS + int'(b.lvl) : 0;
    if (b.act == ACT_READ) begin
      // a read ignores the first-of-spectrum flag
      cell_count_q.push_back(on_grid ? hit_cnt[idx] : '0);
    end else begin
      if (b.first) begin
        if (sweep_left <= 1) begin
          grid_decay();
          sweep_left = decay_period_reg;
        end else begin
          sweep_left = sweep_left - 1'b1;
        end
      end
      if (on_grid) begin
        if (hit_cnt[idx] < CNT_FAST_LIM)
          hit_cnt[idx] = hit_cnt[idx] + CNT_FAST_INC;
        else if (hit_cnt[idx] < CNT_SAT)
          hit_cnt[idx] = hit_cnt[idx] + 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: one beat on the bus at a time, valid held until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_in
    bit taken;
    taken = in_tvalid && in_tready;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (taken)
        grid_apply(beat_on_bus);
      if (!in_tvalid || taken) begin
        if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
          beat_on_bus = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= beat_on_bus.act;
          in_tdata  <= {4'd0, beat_on_bus.first, beat_on_bus.lvl, beat_on_bus.col};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst_n)
      out_tready <= 1'b0;
    else if (rx_holding)
      out_tready <= 1'b0;
    else if (calm)
      out_tready <= 1'b1;
    else
      out_tready <= ($urandom_range(99) >= 33);
  end

  // length of the long hold-off, counted here
  always @(posedge clk) begin
    if (rx_holding) begin
      if (rx_hold_cnt == RX_HOLD_LEN)
        pressure_done <= 1'b1;
      else
        rx_hold_cnt <= rx_hold_cnt + 1;
    end
  end

  task automatic note_error(input string what, input int exp_val, input int got_val);
    if (errors < MAX_REPORTS)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, exp_val, got_val);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // monitor: each result beat against the oldest expected cell count
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_out
    logic [COUNT_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (cell_count_q.size() == 0) begin
        note_error("result beat with nothing expected", -1, int'(out_tdata));
      end else begin
        want = cell_count_q.pop_front();
        if (out_tdata[COUNT_W-1:0] !== want)
          note_error("cell_count mismatch", int'(want), int'(out_tdata));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("spectrum_persistence_histogram verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // queue a beat; first-of-spectrum flags that would start a sweep past the
  // phase's budget are cleared, since every sweep walks the whole grid
  task automatic push_beat(input action_t a, input int c, input int l, input bit f);
    beat_t b;
    if (a == ACT_ACCUMULATE && f) begin
      if (gen_countdown <= 1) begin
        if (sweeps_allowed > 0) begin
          sweeps_allowed--;
          gen_countdown = gen_period;
        end else begin
          f = 1'b0;
        end
      end else begin
        gen_countdown--;
      end
    end
    b.act   = a;
    b.col   = c[COL_W-1:0];
    b.lvl   = l[LEVEL_W-1:0];
    b.first = f;
    pending_beats.push_back(b);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DECAY_PERIOD) begin
      decay_period_reg = val;
      gen_period       = val;
    end else begin
      late_hold_reg = val;
    end
  endtask

  // a closing read fences any sweep still running, then everything drains;
  // checked between edges so the driver's updates have settled
  task automatic wait_drained();
    @(negedge clk);
    push_beat(ACT_READ, hot_col[0], hot_row[0], 1'b0);
    while (pending_beats.size() != 0 || in_tvalid || cell_count_q.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic pick_cell(input int hot_pct, input int any_pct, output int c, output int l);
    int r;
    int k;
    r = $urandom_range(99);
    if (r < hot_pct) begin
      k = $urandom_range(HOT_CELLS - 1);
      c = hot_col[k];
      l = hot_row[k];
    end else if (r < hot_pct + any_pct) begin
      c = $urandom_range(BINS - 1);
      l = $urandom_range(ROWS - 1);
    end else if (r < hot_pct + any_pct + 5) begin
      // cells of the directed part, left to decay slowly
      c = ($urandom_range(1) != 0) ? 511 : 0;
      l = ($urandom_range(1) != 0) ? 99 : 0;
    end else begin
      // any level bits, mostly off the grid
      c = $urandom_range(BINS - 1);
      l = $urandom_range(1023);
    end
  endtask

  task automatic random_beats(input int n, input int sweep_budget);
    int c;
    int l;
    sweeps_allowed = sweep_budget;
    @(negedge clk);
    repeat (n) begin
      if ($urandom_range(99) < 35) begin
        pick_cell(50, 25, c, l);
        push_beat(ACT_READ, c, l, ($urandom_range(7) == 0));
      end else begin
        pick_cell(60, 20, c, l);
        push_beat(ACT_ACCUMULATE, c, l, ($urandom_range(15) == 0));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      hit_cnt[i]  = '0;
      hold_cnt[i] = HOLD_RST;
    end
    sweep_left       = DECAY_PERIOD_RST;
    decay_period_reg = DECAY_PERIOD_RST;
    late_hold_reg    = LATE_HOLD_RST;
    gen_countdown    = DECAY_PERIOD_RST;
    gen_period       = DECAY_PERIOD_RST;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part with the reset settings; the clearing pass runs first
    sweeps_allowed = 1;
    @(negedge clk);
    push_beat(ACT_ACCUMULATE, 0,   0,    1'b1);
    push_beat(ACT_ACCUMULATE, 511, 99,   1'b0);
    push_beat(ACT_ACCUMULATE, 511, 0,    1'b0);
    push_beat(ACT_ACCUMULATE, 0,   99,   1'b0);
    push_beat(ACT_ACCUMULATE, 5,   100,  1'b0);  // row just past the grid
    push_beat(ACT_ACCUMULATE, 5,   -1,   1'b0);
    push_beat(ACT_ACCUMULATE, 5,   -512, 1'b0);
    push_beat(ACT_ACCUMULATE, 5,   511,  1'b1);  // off grid, countdown still steps
    push_beat(ACT_READ,       0,   0,    1'b0);
    push_beat(ACT_READ,       511, 99,   1'b0);
    push_beat(ACT_READ,       5,   100,  1'b0);  // read off the grid gives zero
    push_beat(ACT_READ,       5,   -512, 1'b0);
    push_beat(ACT_READ,       0,   0,    1'b1);  // flag ignored on a read
    push_beat(ACT_ACCUMULATE, 1,   1,    1'b1);
    push_beat(ACT_ACCUMULATE, 1,   1,    1'b1);  // countdown expiry, sweep first
    push_beat(ACT_READ,       1,   1,    1'b0);
    push_beat(ACT_READ,       0,   99,   1'b0);
    push_beat(ACT_READ,       511, 0,    1'b0);
    push_beat(ACT_READ,       511, 511,  1'b0);
    wait_drained();

    // shortest period and no late holdoff: once the old countdown runs out, every spectrum sweeps
    cfg_write(REG_DECAY_PERIOD, 8'd1);
    cfg_write(REG_LATE_HOLD, 8'd0);
    random_beats(200, 4);
    wait_drained();

    // longest period, longest late holdoff, neither side idling
    cfg_write(REG_DECAY_PERIOD, 8'd255);
    cfg_write(REG_LATE_HOLD, 8'd255);
    calm <= 1'b1;
    random_beats(500, 1);
    wait_drained();
    calm <= 1'b0;

    // mid settings; the sender waits for the results halfway through
    cfg_write(REG_DECAY_PERIOD, 8'd3);
    cfg_write(REG_LATE_HOLD, 8'd2);
    random_beats(250, 2);
    wait_drained();
    random_beats(250, 2);
    wait_drained();

    // receiver holds off for a long stretch so the read backs up the input
    cfg_write(REG_DECAY_PERIOD, 8'd2);
    cfg_write(REG_LATE_HOLD, LATE_HOLD_RST);
    @(posedge clk);
    pressure_on <= 1'b1;
    random_beats(400, 2);
    wait_drained();

    repeat (20) @(posedge clk);
    if (cell_count_q.size() != 0)
      note_error("cell counts never returned", 0, cell_count_q.size());
    if (errors == 0)
      $display("spectrum_persistence_histogram verification clean");
    else
      $display("spectrum_persistence_histogram verification failed");
    $finish;
  end

endmodule

`default_nettype wire
